// ----- rtl/core/pss_pkg.sv -----
package pss_pkg;

  // sample and result widths
  localparam int SAMPLE_BITS = 12;
  localparam int POS_W       = 8;
  localparam int NUM_W       = SAMPLE_BITS + POS_W;
  localparam int STEP_W      = $clog2(POS_W);
  localparam int CFG_IDX_W   = 3;

  localparam logic [POS_W-1:0] FULL_SCALE = {POS_W{1'b1}};

  // register reset values
  localparam logic [SAMPLE_BITS-1:0] THR_LO_RST   = SAMPLE_BITS'(360);
  localparam logic [SAMPLE_BITS-1:0] THR_HI_RST   = SAMPLE_BITS'(2000);
  localparam logic [SAMPLE_BITS-1:0] STR_LO_RST   = SAMPLE_BITS'(570);
  localparam logic [SAMPLE_BITS-1:0] STR_HI_RST   = SAMPLE_BITS'(2600);
  localparam logic [POS_W-1:0]       THR_CTR_RST  = POS_W'(127);
  localparam logic [POS_W-1:0]       STR_CTR_RST  = POS_W'(127);
  localparam logic [POS_W-1:0]       THR_WIN_RST  = POS_W'(5);
  localparam logic [POS_W-1:0]       STR_WIN_RST  = POS_W'(15);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_LO  = 3'd0,
    CFG_THR_HI  = 3'd1,
    CFG_STR_LO  = 3'd2,
    CFG_STR_HI  = 3'd3,
    CFG_THR_CTR = 3'd4,
    CFG_STR_CTR = 3'd5,
    CFG_THR_WIN = 3'd6,
    CFG_STR_WIN = 3'd7
  } pss_cfg_t;

  // top level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } pss_state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] throttle_raw;
    logic [SAMPLE_BITS-1:0] steer_raw;
    logic                   arm_pin;
    logic                   steer_enable_pin;
  } pss_in_t;

  typedef struct packed {
    logic [POS_W-1:0] throttle_pos;
    logic [POS_W-1:0] steer_pos;
    logic             arm_out;
    logic             steer_enabled;
    logic             throttle_lamp;
    logic             steer_lamp;
  } pss_out_t;

  // lane status toward the sequencer and merge stage
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] q;
  } pss_lane_st_t;

  // neutral window settings
  typedef struct packed {
    logic [POS_W-1:0] thr_ctr;
    logic [POS_W-1:0] str_ctr;
    logic [POS_W-1:0] thr_win;
    logic [POS_W-1:0] str_win;
  } pss_win_cfg_t;

endpackage

// ----- rtl/core/pss_lane.sv -----
module pss_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pss_pkg::SAMPLE_BITS-1:0] raw,
  input  logic [pss_pkg::SAMPLE_BITS-1:0] lo,
  input  logic [pss_pkg::SAMPLE_BITS-1:0] hi,
  output pss_pkg::pss_lane_st_t          st
);
  import pss_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [STEP_W-1:0]      cnt_r, cnt_nxt;
  logic                   spec_r, spec_nxt;
  logic [NUM_W-1:0]       rem_r, rem_nxt;
  logic [NUM_W-1:0]       div_r, div_nxt;
  logic [POS_W-1:0]       q_r, q_nxt;

  logic [SAMPLE_BITS-1:0] clamp;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] span;
  logic [NUM_W-1:0]       num;
  logic [NUM_W:0]         trial;

  // clamp and scale numerator: (c - lo) * 255
  always_comb begin
    if (raw < lo) begin
      clamp = lo;
    end else if (raw > hi) begin
      clamp = hi;
    end else begin
      clamp = raw;
    end
    diff  = clamp - lo;
    span  = hi - lo;
    num   = {diff, {POS_W{1'b0}}} - NUM_W'(diff);
    trial = {1'b0, rem_r} - {1'b0, div_r};
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    spec_nxt = spec_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      div_nxt  = NUM_W'(span) << (POS_W - 1);
      // zero span gives 0, inverted limits give a step at lo
      if (hi == lo) begin
        spec_nxt = 1'b1;
        q_nxt    = '0;
      end else if (hi < lo) begin
        spec_nxt = 1'b1;
        q_nxt    = (raw < lo) ? '0 : FULL_SCALE;
      end else begin
        spec_nxt = 1'b0;
        q_nxt    = '0;
      end
    end else if (busy_r) begin
      if (!spec_r) begin
        if (!trial[NUM_W]) begin
          rem_nxt = trial[NUM_W-1:0];
          q_nxt   = {q_r[POS_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[POS_W-2:0], 1'b0};
        end
      end
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spec_r <= spec_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
  end

  assign st = '{busy: busy_r, done: done_r, q: q_r};

  // done follows the last divide step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("lane done without a running divide");

endmodule

// ----- rtl/core/pss_merge.sv -----
module pss_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           update,
  input  logic [pss_pkg::POS_W-1:0]      thr_q,
  input  logic [pss_pkg::POS_W-1:0]      str_q,
  input  logic                           arm_pin,
  input  logic                           steer_enable_pin,
  input  pss_pkg::pss_win_cfg_t          win,
  output pss_pkg::pss_out_t              res
);
  import pss_pkg::*;

  localparam int WIN_W = POS_W + 2;

  logic arm_r, arm_nxt;
  logic fault_r, fault_nxt;
  logic tlamp_r, tlamp_nxt;
  logic slamp_r, slamp_nxt;

  logic [POS_W-1:0]        str_pos;
  logic signed [WIN_W-1:0] t_x, t_lo, t_hi;
  logic signed [WIN_W-1:0] s_x, s_lo, s_hi;
  logic                    t_in, t_out, s_in, s_out;
  logic                    req;
  logic                    fault_mid;

  // window edges as signed values
  always_comb begin
    str_pos = FULL_SCALE - str_q;
    t_x   = signed'(WIN_W'(thr_q));
    s_x   = signed'(WIN_W'(str_pos));
    t_lo  = signed'(WIN_W'(win.thr_ctr)) - signed'(WIN_W'(win.thr_win));
    t_hi  = signed'(WIN_W'(win.thr_ctr)) + signed'(WIN_W'(win.thr_win));
    s_lo  = signed'(WIN_W'(win.str_ctr)) - signed'(WIN_W'(win.str_win));
    s_hi  = signed'(WIN_W'(win.str_ctr)) + signed'(WIN_W'(win.str_win));
    t_in  = (t_lo < t_x) && (t_x < t_hi);
    t_out = (t_lo > t_x) || (t_x > t_hi);
    s_in  = (s_lo < s_x) && (s_x < s_hi);
    s_out = (s_lo > s_x) || (s_x > s_hi);
  end

  // lamp hysteresis and arm interlock
  always_comb begin
    tlamp_nxt = tlamp_r;
    slamp_nxt = slamp_r;
    if (t_in)  tlamp_nxt = 1'b1;
    if (t_out) tlamp_nxt = 1'b0;
    if (s_in)  slamp_nxt = 1'b1;
    if (s_out) slamp_nxt = 1'b0;

    req       = ~arm_pin;
    fault_mid = req ? fault_r : 1'b0;
    arm_nxt   = arm_r;
    fault_nxt = fault_mid;
    if (req != arm_r) begin
      if (t_in && s_in && !fault_mid) begin
        arm_nxt = req;
      end else begin
        arm_nxt   = 1'b0;
        fault_nxt = 1'b1;
      end
    end

    res = '{throttle_pos:  thr_q,
            steer_pos:     str_pos,
            arm_out:       arm_nxt,
            steer_enabled: ~steer_enable_pin,
            throttle_lamp: tlamp_nxt,
            steer_lamp:    slamp_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_r   <= 1'b0;
      fault_r <= 1'b0;
      tlamp_r <= 1'b0;
      slamp_r <= 1'b0;
    end else if (update) begin
      arm_r   <= arm_nxt;
      fault_r <= fault_nxt;
      tlamp_r <= tlamp_nxt;
      slamp_r <= slamp_nxt;
    end
  end

  // a stored fault always keeps the latch open
  a_arm_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(arm_r && fault_r))
    else $error("arm latched while a fault is stored");

endmodule

// ----- rtl/core/pedal_steer_scaler_with_arm_interlock.sv -----
// Pedal and steering scaler with arm interlock.
// Input channel in_valid/in_stall/in_data carries one throttle sample, one
// steering sample and the active-low arm and steering-enable pins. Output
// channel out_valid/out_stall/out_data carries the scaled positions, the
// arm latch, the steering enable and the two neutral lamps.
// Two lanes, one per control, clamp and scale their sample with a serial
// restoring divide, one quotient bit per cycle; a merge stage then applies
// the lamp hysteresis and the arm interlock.
// The block takes one item at a time; each item goes through the load,
// eight divide steps, a check that sees both lanes done, and the merge.
// in_stall is high while an item is in work; the next item may be taken
// while a finished result still sits in the output register.
// When the receiver stalls, the output register holds its result and a
// further finished item waits in the lanes until the register frees up.
// cfg_we writes register cfg_index with cfg_wdata; the user must write
// only while the block is idle, which the block itself does not enforce.
// Synchronous active-low reset clears the arm latch, the fault, both lamps
// and the output valid, and loads the calibration registers with defaults.
module pedal_steer_scaler_with_arm_interlock (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pss_pkg::pss_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pss_pkg::pss_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pss_pkg::SAMPLE_BITS-1:0]   cfg_wdata
);
  import pss_pkg::*;

  pss_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] thr_lo_r, thr_hi_r, str_lo_r, str_hi_r;
  logic [POS_W-1:0]       thr_ctr_r, str_ctr_r, thr_win_r, str_win_r;

  logic         arm_pin_r, en_pin_r;
  logic         out_valid_r, out_valid_nxt;
  pss_out_t     out_data_r;
  pss_out_t     merge_res;
  pss_lane_st_t thr_st, str_st;
  pss_win_cfg_t win;
  logic         in_xfer;
  logic         merge_go;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_lo_r  <= THR_LO_RST;
      thr_hi_r  <= THR_HI_RST;
      str_lo_r  <= STR_LO_RST;
      str_hi_r  <= STR_HI_RST;
      thr_ctr_r <= THR_CTR_RST;
      str_ctr_r <= STR_CTR_RST;
      thr_win_r <= THR_WIN_RST;
      str_win_r <= STR_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THR_LO:  thr_lo_r  <= cfg_wdata;
        CFG_THR_HI:  thr_hi_r  <= cfg_wdata;
        CFG_STR_LO:  str_lo_r  <= cfg_wdata;
        CFG_STR_HI:  str_hi_r  <= cfg_wdata;
        CFG_THR_CTR: thr_ctr_r <= cfg_wdata[POS_W-1:0];
        CFG_STR_CTR: str_ctr_r <= cfg_wdata[POS_W-1:0];
        CFG_THR_WIN: thr_win_r <= cfg_wdata[POS_W-1:0];
        CFG_STR_WIN: str_win_r <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign win = '{thr_ctr: thr_ctr_r, str_ctr: str_ctr_r,
                 thr_win: thr_win_r, str_win: str_win_r};

  // pin levels for the item in work
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      arm_pin_r <= in_data.arm_pin;
      en_pin_r  <= in_data.steer_enable_pin;
    end
  end

  // one lane per control
  pss_lane u_thr_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .raw   (in_data.throttle_raw),
    .lo    (thr_lo_r),
    .hi    (thr_hi_r),
    .st    (thr_st)
  );

  pss_lane u_str_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .raw   (in_data.steer_raw),
    .lo    (str_lo_r),
    .hi    (str_hi_r),
    .st    (str_st)
  );

  pss_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .update           (merge_go),
    .thr_q            (thr_st.q),
    .str_q            (str_st.q),
    .arm_pin          (arm_pin_r),
    .steer_enable_pin (en_pin_r),
    .win              (win),
    .res              (merge_res)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    merge_go      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (thr_st.done && str_st.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          merge_go      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (merge_go) out_data_r <= merge_res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // both lanes run the same step count
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    thr_st.done == str_st.done)
    else $error("lanes finished in different cycles");

  // a lane finishes only while an item is in work
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    thr_st.done |-> state_r == ST_RUN)
    else $error("lane result outside of run state");

  // lanes divide only while an item is in work
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (thr_st.busy || str_st.busy) |-> state_r == ST_RUN)
    else $error("lane busy outside of run state");

  // a new result comes only from the merge state
  a_out_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("output valid without a merge");

endmodule
